### hw/rtl/line_input_assembler_macros.svh
// Assertion macros for the line input assembler.
// Both sample on the rising edge of clk; the first is muted while rst is high.
`ifndef LINE_INPUT_ASSEMBLER_MACROS_SVH
`define LINE_INPUT_ASSEMBLER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define LIA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LIA_ASSERT(label, prop, msg)

`define LIA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### hw/rtl/lia_pkg.sv
package lia_pkg;

  localparam int LINE_MAX = 64;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;

  function automatic logic is_command_char(input logic [BYTE_W-1:0] c);
    return (c == CH_DOT) || (c == CH_SLASH) || (c == CH_COMMA);
  endfunction

endpackage

### hw/rtl/line_input_assembler.sv
// Channel   Direction  Handshake               Word
// bytes     in         byte_valid / byte_stall  in_byte
// results   out        line_valid / line_stall  out_char, last_char, empty_line,
//                                               too_long, is_command
// config    in         cfg_valid / cfg_ready    line_limit
//
// A non-terminating byte is taken while the block is idle. A terminator ending a
// non-empty line starts a readout of the line store, which result stalls can hold:
// each character passes through the registered store read and then the output
// register. An empty line's result is registered directly. Reset is synchronous;
// the line store is not cleared, since only entries below the fill count are read.
// Bytes stall during a readout, and a terminator also stalls while a result waits.
`include "line_input_assembler_macros.svh"

module line_input_assembler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [lia_pkg::BYTE_W-1:0]    in_byte,
  output logic                          line_valid,
  input  logic                          line_stall,
  output logic [lia_pkg::BYTE_W-1:0]    out_char,
  output logic                          last_char,
  output logic                          empty_line,
  output logic                          too_long,
  output logic                          is_command,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lia_pkg::LIMIT_W-1:0]   line_limit
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SEND
  } state_t;

  state_t                        state;
  logic [lia_pkg::CNT_W-1:0]     fill_count;
  logic                          overflow_seen;
  logic                          after_term;
  logic                          first_cmd;
  logic [lia_pkg::LIMIT_W-1:0]   limit;
  logic [lia_pkg::IDX_W-1:0]     rd_idx;
  logic [lia_pkg::CNT_W-1:0]     line_len;
  logic                          line_ovf;
  logic                          line_cmd;

  logic                          is_term;
  logic                          is_erase;
  logic                          is_print;
  logic [lia_pkg::LIMIT_W-1:0]   eff_limit;
  logic                          has_room;
  logic                          byte_take;
  logic                          line_take;
  logic                          start_line;
  logic                          chunk_last;

  logic                          wr_en;
  logic                          rd_en;
  logic [lia_pkg::IDX_W-1:0]     rd_addr;
  logic [lia_pkg::BYTE_W-1:0]    rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    is_term  = (in_byte == lia_pkg::CH_CR) || (in_byte == lia_pkg::CH_LF);
    is_erase = (in_byte == lia_pkg::CH_BS) || (in_byte == lia_pkg::CH_DEL);
    is_print = in_byte inside {[lia_pkg::CH_SPACE:lia_pkg::CH_TILDE]};
    if (limit == '0) begin
      eff_limit = lia_pkg::LIMIT_W'(1);
    end else if (limit > lia_pkg::LIMIT_W'(lia_pkg::LINE_MAX)) begin
      eff_limit = lia_pkg::LIMIT_W'(lia_pkg::LINE_MAX);
    end else begin
      eff_limit = limit;
    end
    has_room = lia_pkg::LIMIT_W'(fill_count) < eff_limit;
  end

  // A terminator waits until the previous line's final result has left.
  assign byte_stall = (state != S_IDLE) || (line_valid && is_term);
  assign byte_take  = byte_valid && !byte_stall;
  assign line_take  = line_valid && !line_stall;

  assign start_line = byte_take && is_term && !after_term && (fill_count != '0);
  assign chunk_last = ({1'b0, rd_idx} + lia_pkg::CNT_W'(1)) == line_len;

  assign wr_en   = byte_take && is_print && has_room;
  assign rd_en   = start_line || ((state == S_SEND) && line_take && !last_char);
  assign rd_addr = (state == S_IDLE) ? '0 : rd_idx + lia_pkg::IDX_W'(1);

  lia_ram #(
    .WIDTH (lia_pkg::BYTE_W),
    .DEPTH (lia_pkg::LINE_MAX)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[lia_pkg::IDX_W-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      after_term    <= 1'b0;
      first_cmd     <= 1'b0;
      limit         <= lia_pkg::LIMIT_RESET;
      line_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= line_limit;
      end
      if (line_take) begin
        line_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (byte_take) begin
            if (is_term) begin
              if (!after_term) begin
                after_term    <= 1'b1;
                fill_count    <= '0;
                overflow_seen <= 1'b0;
                if (fill_count == '0) begin
                  out_char   <= '0;
                  last_char  <= 1'b1;
                  empty_line <= 1'b1;
                  too_long   <= overflow_seen;
                  is_command <= 1'b0;
                  line_valid <= 1'b1;
                end else begin
                  line_len <= fill_count;
                  line_ovf <= overflow_seen;
                  line_cmd <= first_cmd;
                  rd_idx   <= '0;
                  state    <= S_LOAD;
                end
              end
            end else begin
              after_term <= 1'b0;
              if (is_erase) begin
                if (fill_count != '0) begin
                  fill_count <= fill_count - lia_pkg::CNT_W'(1);
                end
              end else if (is_print) begin
                if (has_room) begin
                  fill_count <= fill_count + lia_pkg::CNT_W'(1);
                  if (fill_count == '0) begin
                    first_cmd <= lia_pkg::is_command_char(in_byte);
                  end
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
            end
          end
        end
        S_LOAD: begin
          out_char   <= rd_data;
          last_char  <= chunk_last;
          empty_line <= 1'b0;
          too_long   <= chunk_last && line_ovf;
          is_command <= chunk_last && line_cmd;
          line_valid <= 1'b1;
          state      <= S_SEND;
        end
        S_SEND: begin
          if (line_take) begin
            if (last_char) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + lia_pkg::IDX_W'(1);
              state  <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LIA_ASSERT(a_fill_in_range, fill_count <= lia_pkg::CNT_W'(lia_pkg::LINE_MAX), "fill count beyond line store")
  `LIA_ASSERT(a_no_write_in_readout, (state != S_IDLE) |-> !wr_en, "line store written during readout")
  `LIA_ASSERT(a_load_after_term, (state == S_LOAD) |-> (after_term && (fill_count == '0)), "readout without cleared line")
  `LIA_ASSERT(a_empty_is_final, (line_valid && empty_line) |-> (last_char && (out_char == '0) && !is_command), "bad empty line result")
  `LIA_ASSERT_ALWAYS(a_reset_no_result, rst |=> !line_valid, "result valid after reset")

endmodule

### hw/rtl/lia_ram.sv
module lia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [lia_pkg::BYTE_W-1:0] ch;
    logic                       last;
    logic                       empty;
    logic                       over;
    logic                       cmd;
  } line_word_t;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        byte_valid = 1'b0;
  logic                        byte_stall;
  logic [lia_pkg::BYTE_W-1:0]  in_byte    = '0;
  logic                        line_valid;
  logic                        line_stall = 1'b0;
  logic [lia_pkg::BYTE_W-1:0]  out_char;
  logic                        last_char;
  logic                        empty_line;
  logic                        too_long;
  logic                        is_command;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [lia_pkg::LIMIT_W-1:0] line_limit = lia_pkg::LIMIT_RESET;

  line_input_assembler dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .in_byte    (in_byte),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .out_char   (out_char),
    .last_char  (last_char),
    .empty_line (empty_line),
    .too_long   (too_long),
    .is_command (is_command),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .line_limit (line_limit)
  );

  always #10 clk = ~clk;

  // Shadow of the line editor.
  logic [lia_pkg::BYTE_W-1:0]  line_buf [lia_pkg::LINE_MAX];
  int                          fill_now     = 0;
  bit                          overflow_now = 1'b0;
  bit                          after_term   = 1'b0;
  logic [lia_pkg::LIMIT_W-1:0] limit_now    = lia_pkg::LIMIT_RESET;

  line_word_t                  words_due [$];
  logic [lia_pkg::BYTE_W-1:0]  byte_backlog [$];

  int   errors        = 0;
  int   bytes_taken   = 0;
  int   lines_ended   = 0;
  int   words_checked = 0;
  int   limits_used   = 0;

  logic byte_taken = 1'b0;
  logic line_taken = 1'b0;
  int   gap_left   = 0;
  int   stall_left = 3;
  bit   in_steady  = 1'b0;
  bit   out_steady = 1'b0;

  function automatic int cap_of(logic [lia_pkg::LIMIT_W-1:0] lim);
    if (lim == 0) return 1;
    if (lim > lia_pkg::LINE_MAX) return lia_pkg::LINE_MAX;
    return int'(lim);
  endfunction

  function automatic void absorb_byte(logic [lia_pkg::BYTE_W-1:0] b);
    line_word_t w;
    logic       lead_cmd;
    bytes_taken++;
    if (b == lia_pkg::CH_CR || b == lia_pkg::CH_LF) begin
      // Only the first terminator of a run closes the line.
      if (!after_term) begin
        after_term = 1'b1;
        lines_ended++;
        if (fill_now == 0) begin
          w.ch    = '0;
          w.last  = 1'b1;
          w.empty = 1'b1;
          w.over  = overflow_now;
          w.cmd   = 1'b0;
          words_due.push_back(w);
        end else begin
          lead_cmd = (line_buf[0] == lia_pkg::CH_DOT) || (line_buf[0] == lia_pkg::CH_SLASH) ||
                     (line_buf[0] == lia_pkg::CH_COMMA);
          for (int k = 0; k < fill_now; k++) begin
            w.ch    = line_buf[k];
            w.last  = (k == fill_now - 1);
            w.empty = 1'b0;
            w.over  = w.last && overflow_now;
            w.cmd   = w.last && lead_cmd;
            words_due.push_back(w);
          end
        end
        fill_now     = 0;
        overflow_now = 1'b0;
      end
    end else begin
      after_term = 1'b0;
      if (b == lia_pkg::CH_BS || b == lia_pkg::CH_DEL) begin
        if (fill_now > 0) fill_now--;
      end else if (b >= lia_pkg::CH_SPACE && b <= lia_pkg::CH_TILDE) begin
        if (fill_now < cap_of(limit_now) && fill_now < lia_pkg::LINE_MAX) begin
          line_buf[fill_now] = b;
          fill_now++;
        end else begin
          overflow_now = 1'b1;
        end
      end
    end
  endfunction

  function automatic void check_field(string name, logic [lia_pkg::BYTE_W-1:0] want,
                                      logic [lia_pkg::BYTE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_word();
    line_word_t want;
    if (words_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: expected none, actual char %h last %b empty %b",
               $time, out_char, last_char, empty_line);
      return;
    end
    want = words_due.pop_front();
    words_checked++;
    check_field("out_char", want.ch, out_char);
    check_field("last_char", 8'(want.last), 8'(last_char));
    check_field("empty_line", 8'(want.empty), 8'(empty_line));
    check_field("too_long", 8'(want.over), 8'(too_long));
    check_field("is_command", 8'(want.cmd), 8'(is_command));
  endfunction

  // Monitor: outputs are sampled at the rising edge.
  always @(posedge clk) begin
    byte_taken <= !rst && byte_valid && !byte_stall;
    line_taken <= !rst && line_valid && !line_stall;
    if (!rst) begin
      if (line_valid && !line_stall) check_word();
      if (byte_valid && !byte_stall) absorb_byte(in_byte);
    end
  end

  // Byte driver: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      if (gap_left > 0) begin
        byte_valid <= 1'b0;
        gap_left--;
      end else if (byte_backlog.size() != 0) begin
        in_byte    <= byte_backlog.pop_front();
        byte_valid <= 1'b1;
        if ($urandom_range(0, 15) == 0) in_steady = !in_steady;
        gap_left = in_steady ? 0 : $urandom_range(0, 5);
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Result stalls: a new stall is drawn after each taken word and runs down only while valid.
  always @(negedge clk) begin
    if (rst) begin
      line_stall <= 1'b0;
    end else begin
      if (line_taken) begin
        if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
        stall_left = out_steady ? 0 : $urandom_range(0, 5);
      end
      if (stall_left > 0) begin
        line_stall <= 1'b1;
        if (line_valid) stall_left--;
      end else begin
        line_stall <= 1'b0;
      end
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) byte_backlog.push_back(s[i]);
  endtask

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || byte_valid || words_due.size() != 0)
      @(posedge clk);
    // A byte that yields no result may still be in the block.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_limit(logic [lia_pkg::LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    line_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_now = v;
    limits_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_lines(int quota);
    int                         cap;
    int                         len;
    int                         n;
    logic [lia_pkg::BYTE_W-1:0] b;
    n   = 0;
    cap = cap_of(limit_now);
    while (n < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          byte_backlog.push_back(8'($urandom_range(0, 255)));
          n++;
        end
      end else begin
        if ($urandom_range(0, 7) == 0) len = cap + $urandom_range(0, 3);
        else len = $urandom_range(0, (cap < 9) ? cap + 1 : 10);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 11))
            0: b = $urandom_range(0, 1) ? lia_pkg::CH_BS : lia_pkg::CH_DEL;
            1: begin
              b = 8'($urandom_range(0, 255));
              if (b == lia_pkg::CH_CR || b == lia_pkg::CH_LF) b = 8'h00;
            end
            default: b = 8'($urandom_range(lia_pkg::CH_SPACE, lia_pkg::CH_TILDE));
          endcase
          if (i == 0 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
              0: b = lia_pkg::CH_DOT;
              1: b = lia_pkg::CH_SLASH;
              default: b = lia_pkg::CH_COMMA;
            endcase
          end
          byte_backlog.push_back(b);
          n++;
        end
        byte_backlog.push_back($urandom_range(0, 1) ? lia_pkg::CH_CR : lia_pkg::CH_LF);
        n++;
        if ($urandom_range(0, 3) == 0) begin
          byte_backlog.push_back($urandom_range(0, 1) ? lia_pkg::CH_CR : lia_pkg::CH_LF);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An empty line straight out of reset, then a terminator run.
    byte_backlog.push_back(lia_pkg::CH_CR);
    byte_backlog.push_back(lia_pkg::CH_LF);
    // Control and high bytes are dropped; an erase removes the tilde.
    push_text(",A");
    byte_backlog.push_back(8'h00);
    byte_backlog.push_back(8'hFF);
    byte_backlog.push_back(8'h1F);
    byte_backlog.push_back(8'h80);
    push_text("~");
    byte_backlog.push_back(lia_pkg::CH_BS);
    push_text("z");
    byte_backlog.push_back(lia_pkg::CH_CR);
    byte_backlog.push_back(lia_pkg::CH_LF);
    byte_backlog.push_back(lia_pkg::CH_CR);
    // Erases on an empty line do nothing.
    byte_backlog.push_back(lia_pkg::CH_BS);
    byte_backlog.push_back(lia_pkg::CH_DEL);
    push_text(" /");
    byte_backlog.push_back(lia_pkg::CH_CR);
    push_text("/q");
    byte_backlog.push_back(lia_pkg::CH_LF);
    // A line erased back to nothing ends as an empty line.
    push_text(".");
    byte_backlog.push_back(lia_pkg::CH_BS);
    byte_backlog.push_back(lia_pkg::CH_DEL);
    byte_backlog.push_back(lia_pkg::CH_LF);
    wait_idle();

    // At the smallest limit, overflow survives erasing the whole line.
    set_line_limit(lia_pkg::LIMIT_W'(1));
    push_text("abc");
    byte_backlog.push_back(lia_pkg::CH_CR);
    push_text("xy");
    byte_backlog.push_back(lia_pkg::CH_DEL);
    byte_backlog.push_back(lia_pkg::CH_BS);
    byte_backlog.push_back(lia_pkg::CH_CR);
    wait_idle();

    // The largest register value acts as the full line length.
    set_line_limit(lia_pkg::LIMIT_W'(127));
    for (int i = 0; i < lia_pkg::LINE_MAX + 1; i++) byte_backlog.push_back(8'h41 + 8'(i % 26));
    byte_backlog.push_back(lia_pkg::CH_CR);
    wait_idle();

    // Lower the limit while a line is half written.
    set_line_limit(lia_pkg::LIMIT_W'(64));
    push_text("hello");
    wait_idle();
    set_line_limit(lia_pkg::LIMIT_W'(3));
    push_text("w");
    byte_backlog.push_back(lia_pkg::CH_CR);
    wait_idle();

    set_line_limit(lia_pkg::LIMIT_W'(0));
    add_random_lines(3);
    wait_idle();
    set_line_limit(lia_pkg::LIMIT_W'($urandom_range(2, 10)));
    add_random_lines(3);
    wait_idle();

    repeat (2 * lia_pkg::LINE_MAX + 8) @(posedge clk);
    $display("Run covered %0d bytes under %0d limit settings.", bytes_taken, limits_used);
    $display("It checked %0d result words from %0d finished lines.",
             words_checked, lines_ended);
    if (errors == 0 && words_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result words still due.", words_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
